>>> hw/rtl/ks0108_lcd_refresh_sequencer_assert.svh
// Assertion macros shared by the refresh sequencer RTL.
`ifndef KS0108_LCD_REFRESH_SEQUENCER_ASSERT_SVH
`define KS0108_LCD_REFRESH_SEQUENCER_ASSERT_SVH

// Checked only while out of reset.
`define KS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define KS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/ks0108_pkg.sv
package ks0108_pkg;

    // Frame buffer geometry.
    localparam int FRAME_BYTES  = 1024;
    localparam int ADDR_W       = $clog2(FRAME_BYTES);
    localparam int HALF_COLUMNS = 64;
    localparam int PAGES        = 8;

    // Display bus bytes.
    localparam logic [7:0] CMD_PAGE   = 8'hB8;
    localparam logic [7:0] CMD_Y      = 8'h40;
    localparam logic [7:0] CMD_START  = 8'hC0;
    localparam logic [7:0] CMD_ON     = 8'h3F;
    localparam logic [7:0] CLEAR_BYTE = 8'hAA;

    // Item operation codes.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_INIT  = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } item_t;

    typedef struct packed {
        logic       chip_left;
        logic       chip_right;
        logic       data_mode;
        logic [7:0] bus_data;
        logic       last;
        logic       frame_done;
    } beat_t;

    // One access to the frame buffer; write and read never share a cycle.
    typedef struct packed {
        logic              wr;
        logic              rd;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } fb_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_STEP,
        ST_GATHER,
        ST_DRAIN,
        ST_DATA
    } seq_state_t;

    typedef enum logic [1:0] {
        PH_PAGE,
        PH_YRST,
        PH_YCMD,
        PH_DATA
    } phase_t;

endpackage

>>> hw/rtl/ks0108_frame_buf.sv
`include "ks0108_lcd_refresh_sequencer_assert.svh"

module ks0108_frame_buf
    import ks0108_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  fb_req_t    req,
    output logic [7:0] rd_data,
    output logic       busy
);

    logic [7:0]        mem [FRAME_BYTES];
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic              busy_reg;
    logic              busy_next;
    logic              we;
    logic [ADDR_W-1:0] wa;
    logic [7:0]        wd;

    // Clearing pass after reset: one byte per cycle over the whole buffer.
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        busy_next     = busy_reg;
        if (busy_reg)
        begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(FRAME_BYTES - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            busy_reg     <= busy_next;
        end
    end

    // Write port is shared between the clearing pass and frame writes.
    assign we = busy_reg | req.wr;
    assign wa = busy_reg ? clr_addr_reg : req.addr;
    assign wd = busy_reg ? CLEAR_BYTE : req.wdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (req.rd)
        begin
            rd_data <= mem[req.addr];
        end
    end

    assign busy = busy_reg;

    `KS_ASSERT(a_no_access_while_clearing, busy_reg |-> (!req.wr && !req.rd),
               "frame buffer accessed during clearing pass")
    `KS_ASSERT(a_clear_ends_at_top, $fell(busy_reg) |-> ($past(clr_addr_reg) == ADDR_W'(FRAME_BYTES - 1)),
               "clearing pass ended early")

endmodule

>>> hw/rtl/ks0108_lcd_refresh_sequencer.sv
// Two-chip KS0108-style LCD refresh sequencer with a 64-row by 16-byte frame buffer. After
// reset the buffer is filled with 0xAA by a clearing pass, during which item_stall stays
// high. A frame write goes straight to the buffer. An init item gives four instruction
// beats, one per cycle while the output is free; a command step loads its beat once the
// output is free. A data step reads the eight frame bytes of the 8x8 transpose one per
// cycle through the single read port of the frame buffer, waits in the drain state for the
// registered read data and then loads the output register. One item is worked on at a
// time; a finished beat waits in the output register while the next item is taken.
`include "ks0108_lcd_refresh_sequencer_assert.svh"

module ks0108_lcd_refresh_sequencer
    import ks0108_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_stall,
    input  item_t item,
    output logic  beat_valid,
    input  logic  beat_stall,
    output beat_t beat
);

    seq_state_t state_reg;
    seq_state_t state_next;
    phase_t     phase_reg;
    phase_t     phase_next;
    logic       half_reg;
    logic       half_next;
    logic [2:0] page_reg;
    logic [2:0] page_next;
    logic [5:0] col_reg;
    logic [5:0] col_next;
    logic [1:0] init_cnt_reg;
    logic [1:0] init_cnt_next;
    logic [2:0] gcnt_reg;
    logic [2:0] gcnt_next;
    logic       capt_reg;
    logic       capt_next;
    logic [7:0] bits_reg;
    logic [7:0] bits_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    beat_t      out_reg;
    beat_t      out_next;

    fb_req_t    fb_req;
    logic [7:0] fb_rd_data;
    logic       fb_busy;
    logic       out_free;
    logic       accept;

    ks0108_frame_buf u_frame_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (fb_req),
        .rd_data (fb_rd_data),
        .busy    (fb_busy)
    );

    assign out_free = !out_valid_reg || !beat_stall;
    assign accept   = item_valid && !item_stall;

    // Transpose gather: each returned byte gives one bit, shifted in from the top.
    always_comb
    begin
        capt_next = (state_reg == ST_GATHER);
        bits_next = bits_reg;
        if (capt_reg)
        begin
            bits_next = {fb_rd_data[~col_reg[2:0]], bits_reg[7:1]};
        end
    end

    // Sequencer: next state, refresh position and output beat.
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        half_next      = half_reg;
        page_next      = page_reg;
        col_next       = col_reg;
        init_cnt_next  = init_cnt_reg;
        gcnt_next      = gcnt_reg;
        out_valid_next = out_valid_reg && beat_stall;
        out_next       = out_reg;
        fb_req         = '0;
        item_stall     = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                item_stall = fb_busy;
                if (accept)
                begin
                    case (item.op)
                        OP_WRITE:
                        begin
                            fb_req.wr    = 1'b1;
                            fb_req.addr  = item.addr;
                            fb_req.wdata = item.wdata;
                        end
                        OP_INIT:
                        begin
                            init_cnt_next = '0;
                            state_next    = ST_INIT;
                        end
                        OP_STEP:
                        begin
                            if (phase_reg == PH_DATA)
                            begin
                                gcnt_next  = '0;
                                state_next = ST_GATHER;
                            end
                            else
                            begin
                                state_next = ST_STEP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_INIT:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.chip_left  = !init_cnt_reg[1];
                    out_next.chip_right = init_cnt_reg[1];
                    out_next.data_mode  = 1'b0;
                    out_next.bus_data   = init_cnt_reg[0] ? CMD_ON : CMD_START;
                    out_next.last       = (init_cnt_reg == 2'd3);
                    out_next.frame_done = 1'b0;
                    init_cnt_next       = init_cnt_reg + 2'd1;
                    if (init_cnt_reg == 2'd3)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_STEP:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.chip_left  = !half_reg;
                    out_next.chip_right = half_reg;
                    out_next.data_mode  = 1'b0;
                    out_next.last       = 1'b1;
                    out_next.frame_done = 1'b0;
                    case (phase_reg)
                        PH_PAGE:
                        begin
                            out_next.bus_data = CMD_PAGE | {5'd0, page_reg};
                            phase_next        = PH_YRST;
                        end
                        PH_YRST:
                        begin
                            out_next.bus_data = CMD_Y;
                            phase_next        = PH_YCMD;
                        end
                        default:
                        begin
                            out_next.bus_data = CMD_Y | {2'd0, col_reg};
                            phase_next        = PH_DATA;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end

            ST_GATHER:
            begin
                // Byte c of the column block sits c rows below the page's top row.
                fb_req.rd   = 1'b1;
                fb_req.addr = {page_reg, gcnt_reg, half_reg, col_reg[5:3]};
                gcnt_next   = gcnt_reg + 3'd1;
                if (gcnt_reg == 3'd7)
                begin
                    state_next = ST_DRAIN;
                end
            end

            ST_DRAIN:
            begin
                state_next = ST_DATA;
            end

            ST_DATA:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.chip_left  = !half_reg;
                    out_next.chip_right = half_reg;
                    out_next.data_mode  = 1'b1;
                    out_next.bus_data   = bits_reg;
                    out_next.last       = 1'b1;
                    out_next.frame_done = 1'b0;
                    if (col_reg == 6'(HALF_COLUMNS - 1))
                    begin
                        col_next   = '0;
                        phase_next = PH_PAGE;
                        page_next  = page_reg + 3'd1;
                        if (page_reg == 3'(PAGES - 1))
                        begin
                            half_next           = !half_reg;
                            out_next.frame_done = half_reg;
                        end
                    end
                    else
                    begin
                        col_next   = col_reg + 6'd1;
                        phase_next = PH_YCMD;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_PAGE;
            half_reg      <= 1'b0;
            page_reg      <= '0;
            col_reg       <= '0;
            init_cnt_reg  <= '0;
            gcnt_reg      <= '0;
            capt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            half_reg      <= half_next;
            page_reg      <= page_next;
            col_reg       <= col_next;
            init_cnt_reg  <= init_cnt_next;
            gcnt_reg      <= gcnt_next;
            capt_reg      <= capt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        out_reg  <= out_next;
    end

    assign beat_valid = out_valid_reg;
    assign beat       = out_reg;

    `KS_ASSERT(a_gather_only_in_data_phase, (state_reg == ST_GATHER) |-> (phase_reg == PH_DATA),
               "transpose gather outside the data phase")
    `KS_ASSERT(a_data_after_drain, (state_reg == ST_DATA) |-> ($past(state_reg) == ST_DRAIN || $past(state_reg) == ST_DATA),
               "data beat without a complete gather")
    `KS_ASSERT(a_one_chip, beat_valid |-> (beat.chip_left != beat.chip_right),
               "beat selects both or neither chip")
    `KS_ASSERT(a_done_on_right_data, (beat_valid && beat.frame_done) |-> (beat.data_mode && beat.chip_right),
               "frame done on a beat other than right half data")

endmodule
